@@ src/bde_pkg.sv @@
// Shared types, constants and helpers for the bounded deque engine.
// Depends on nothing; used by every module in src/.
`timescale 1ns / 1ps

package bde_pkg;

   localparam int unsigned DEPTH  = 16;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned KEY_W  = 32;

   // operation codes
   localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
   localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
   localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [1:0] MODE_SWAP       = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [KEY_W-1:0] key_in;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [KEY_W-1:0] key_out;
      logic [4:0]              count;
   } rsp_type;

   // decoded operation handed from the pointer unit to the sequencer
   typedef struct packed {
      logic [1:0]        status;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] front_addr;
      logic [ADDR_W-1:0] back_addr;
      logic              is_pop;
      logic              is_swap;
      logic [CNT_W-1:0]  count;
   } plan_type;

   // (pos + delta) mod DEPTH, both operands below DEPTH
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] pos,
                                                  input logic [ADDR_W-1:0] delta);
      logic [ADDR_W:0] sum;
      sum = {1'b0, pos} + {1'b0, delta};
      if (sum >= (ADDR_W + 1)'(DEPTH)) begin
         sum = sum - (ADDR_W + 1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

@@ src/bde_key_ram.sv @@
// Key storage: one write port, two read ports, registered read data.
// Depends on bde_pkg.
`timescale 1ns / 1ps

module bde_key_ram (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [bde_pkg::ADDR_W-1:0]          rd_addr_a,
   input  logic [bde_pkg::ADDR_W-1:0]          rd_addr_b,
   output logic signed [bde_pkg::KEY_W-1:0]    rd_data_a,
   output logic signed [bde_pkg::KEY_W-1:0]    rd_data_b,
   input  logic                                wr_en,
   input  logic [bde_pkg::ADDR_W-1:0]          wr_addr,
   input  logic signed [bde_pkg::KEY_W-1:0]    wr_data
);

   logic signed [bde_pkg::KEY_W-1:0] mem_ff [bde_pkg::DEPTH];
   logic signed [bde_pkg::KEY_W-1:0] rd_a_ff;
   logic signed [bde_pkg::KEY_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ src/bde_ctrl.sv @@
// Front pointer and element count; decodes each transfer into a plan.
// Depends on bde_pkg.
`timescale 1ns / 1ps

module bde_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  bde_pkg::req_type     req,
   output bde_pkg::plan_type    plan
);

   logic [bde_pkg::ADDR_W-1:0] front_ff, front_in;
   logic [bde_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       full, empty;
   logic [bde_pkg::ADDR_W-1:0] front_dec, front_inc, back_addr, tail_addr;
   logic [bde_pkg::CNT_W-1:0]  count_m1;

   assign full      = (count_ff >= bde_pkg::CNT_W'(bde_pkg::DEPTH));
   assign empty     = (count_ff == '0);
   assign count_m1  = count_ff - bde_pkg::CNT_W'(1);
   assign front_dec = bde_pkg::wrap_add(front_ff, bde_pkg::ADDR_W'(bde_pkg::DEPTH - 1));
   assign front_inc = bde_pkg::wrap_add(front_ff, bde_pkg::ADDR_W'(1));
   assign back_addr = bde_pkg::wrap_add(front_ff, count_m1[bde_pkg::ADDR_W-1:0]);
   assign tail_addr = bde_pkg::wrap_add(front_ff, count_ff[bde_pkg::ADDR_W-1:0]);

   always_comb begin
      front_in        = front_ff;
      count_in        = count_ff;
      plan            = '0;
      plan.status     = bde_pkg::STATUS_OK;
      plan.front_addr = front_ff;
      plan.back_addr  = back_addr;
      case (req.mode)
         bde_pkg::MODE_PUSH_FRONT: begin
            if (full) begin
               plan.status = bde_pkg::STATUS_FULL;
            end else begin
               plan.wr_en   = 1'b1;
               plan.wr_addr = front_dec;
               front_in     = front_dec;
               count_in     = count_ff + bde_pkg::CNT_W'(1);
            end
         end
         bde_pkg::MODE_PUSH_BACK: begin
            if (full) begin
               plan.status = bde_pkg::STATUS_FULL;
            end else begin
               plan.wr_en   = 1'b1;
               plan.wr_addr = tail_addr;
               count_in     = count_ff + bde_pkg::CNT_W'(1);
            end
         end
         bde_pkg::MODE_POP_FRONT: begin
            if (empty) begin
               plan.status = bde_pkg::STATUS_EMPTY;
            end else begin
               plan.is_pop = 1'b1;
               front_in    = front_inc;
               count_in    = count_m1;
            end
         end
         default: begin
            if (empty) begin
               plan.status = bde_pkg::STATUS_EMPTY;
            end else begin
               plan.is_swap = 1'b1;
            end
         end
      endcase
      plan.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ src/bounded_deque_engine_core.sv @@
// Top level of the bounded deque engine: sequencer, result register.
// Depends on bde_pkg, bde_ctrl and bde_key_ram.
`timescale 1ns / 1ps

//  channel  direction  payload             handshake
//  req_     in         bde_pkg::req_type   req_valid / req_ready
//  rsp_     out        bde_pkg::rsp_type   rsp_valid / rsp_ready
//
//  One operation at a time. Push, or any refused operation: ST_IDLE, ST_DONE.
//  Pop: ST_IDLE, ST_READ (key store read), ST_DONE. Swap: read, then one write
//  per entry through the key store's single write port (ST_READ, ST_SWAP).
//  Reset clears the front pointer, count, sequencer and result valid at once;
//  the key store is not cleared, only written entries are ever used.
//  A stalled result is held in rsp_payload; the next request is still taken.

module bounded_deque_engine_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bde_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bde_pkg::rsp_type  rsp_payload
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_SWAP = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   bde_pkg::plan_type plan, plan_ff, plan_in;
   bde_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_xfer;
   logic              slot_free;

   // key store ports
   logic                              ram_rd_en;
   logic signed [bde_pkg::KEY_W-1:0]  ram_rd_front, ram_rd_back;
   logic                              ram_wr_en;
   logic [bde_pkg::ADDR_W-1:0]        ram_wr_addr;
   logic signed [bde_pkg::KEY_W-1:0]  ram_wr_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   bde_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (req_xfer),
      .req    (req_payload),
      .plan   (plan)
   );

   // read both ends on every accepted transfer; data holds afterwards
   assign ram_rd_en = req_xfer;

   bde_key_ram u_ram (
      .clock     (clock),
      .rd_en     (ram_rd_en),
      .rd_addr_a (plan.front_addr),
      .rd_addr_b (plan.back_addr),
      .rd_data_a (ram_rd_front),
      .rd_data_b (ram_rd_back),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data)
   );

   // write port: pushes at accept, swap as two writes after the read
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = plan.wr_addr;
      ram_wr_data = req_payload.key_in;
      case (state_ff)
         ST_IDLE: begin
            ram_wr_en = req_xfer && plan.wr_en;
         end
         ST_READ: begin
            ram_wr_en   = plan_ff.is_swap;
            ram_wr_addr = plan_ff.front_addr;
            ram_wr_data = ram_rd_back;
         end
         ST_SWAP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = plan_ff.back_addr;
            ram_wr_data = ram_rd_front;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      plan_in      = plan_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               plan_in  = plan;
               state_in = (plan.is_pop || plan.is_swap) ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            state_in = plan_ff.is_swap ? ST_SWAP : ST_DONE;
         end
         ST_SWAP: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_in.status  = plan_ff.status;
               rsp_in.key_out = plan_ff.is_pop ? ram_rd_front : '0;
               rsp_in.count   = 5'(plan_ff.count);
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---- checks ----
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("request taken while an operation is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.count <= 5'(bde_pkg::DEPTH)))
      else $error("count beyond depth");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == bde_pkg::STATUS_FULL)
         |-> (rsp_ff.count == 5'(bde_pkg::DEPTH)))
      else $error("full status with room left");

   a_refused_no_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != bde_pkg::STATUS_OK) |-> (rsp_ff.key_out == '0))
      else $error("refused operation returned a key");

endmodule
